/* src/assert_macros.svh */
// Assertion macros used by the checker module of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/csal_pkg.sv */
// Package for the conductivity to salinity converter: widths, fixed-point
// coefficients, CSR register indexes and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csal_pkg;

   localparam int EcWidth    = 19;
   localparam int TempWidth  = 14;
   localparam int SalWidth   = 16;
   localparam int RatioWidth = 25;
   localparam int RootWidth  = 23;
   localparam int FracBits   = 20;
   localparam int DivSteps   = RatioWidth;
   localparam int RootSteps  = RootWidth;

   localparam logic [12:0] FactorDen    = 13'd5000;
   localparam logic [15:0] StdEcX1000   = 16'd42914;
   localparam logic [14:0] FactorOffset = 15'd3500;
   localparam logic [TempWidth-1:0] TempReset = 14'd2500;

   localparam logic [13:0] CoefHalf      = 14'd8389;
   localparam logic [17:0] CoefOneHalf   = 18'd177419;
   localparam logic [24:0] CoefTwo       = 25'd26618207;
   localparam logic [23:0] CoefTwoHalf   = 24'd14778735;
   localparam logic [22:0] CoefThree     = 23'd7367400;
   localparam logic [21:0] CoefThreeHalf = 22'd2839649;

   localparam logic [SalWidth-1:0] SalMax = 16'd50000;

   typedef enum logic [0:0] {
      CSR_COMP_TEMP  = 1'b0,
      CSR_TEMP_KNOWN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic no_temp;
      logic zero;
   } flags_type;

endpackage
`default_nettype wire

/* src/csal_div.sv */
// Ratio stage: temperature factor, denominator and a pipelined restoring
// divider that yields R in Q5.20, saturated. Depends on csal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csal_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic [csal_pkg::EcWidth-1:0]   in_ec,
   input  wire logic [csal_pkg::TempWidth-1:0] in_temp,
   input  wire logic                           in_temp_known,
   output logic                                out_valid,
   output logic [csal_pkg::RatioWidth-1:0]     out_ratio,
   output csal_pkg::flags_type                 out_flags
);
   import csal_pkg::*;

   logic                   a_vld_ff;
   logic [EcWidth-1:0]     a_ec_ff;
   logic [13:0]            a_d_ff;
   flags_type              a_flags_ff;
   logic signed [14:0]     d_in;
   flags_type              a_flags_in;

   logic                   b_vld_ff;
   logic [31:0]            b_p_ff;
   logic [29:0]            b_den_ff;
   flags_type              b_flags_ff;

   logic                   vld_ff   [DivSteps+1];
   logic [29:0]            rem_ff   [DivSteps+1];
   logic [RatioWidth-1:0]  quo_ff   [DivSteps+1];
   logic [29:0]            den_ff   [DivSteps+1];
   logic [4:0]             tail_ff  [DivSteps+1];
   logic                   sat_ff   [DivSteps+1];
   flags_type              flags_ff [DivSteps+1];
   logic                   sat_in;

   assign d_in = $signed(FactorOffset) + $signed({in_temp[TempWidth-1], in_temp});
   assign a_flags_in.no_temp = ~in_temp_known;
   assign a_flags_in.zero    = d_in[14] | (d_in == 15'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         vld_ff[0] <= b_vld_ff;
      end
   end

   assign sat_in = {3'b000, b_p_ff[31:5]} >= b_den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ec_ff     <= in_ec;
         a_d_ff      <= d_in[13:0];
         a_flags_ff  <= a_flags_in;
         b_p_ff      <= 32'(a_ec_ff) * 32'(FactorDen);
         b_den_ff    <= 30'(a_d_ff) * 30'(StdEcX1000);
         b_flags_ff  <= a_flags_ff;
         rem_ff[0]   <= sat_in ? 30'd0 : {3'b000, b_p_ff[31:5]};
         quo_ff[0]   <= '0;
         den_ff[0]   <= b_den_ff;
         tail_ff[0]  <= b_p_ff[4:0];
         sat_ff[0]   <= sat_in;
         flags_ff[0] <= b_flags_ff;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic        bit_in;
      logic [30:0] shift_in;
      logic        ge_in;
      if (k < 5) begin : g_tail
         assign bit_in = tail_ff[k][4-k];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end
      assign shift_in = {rem_ff[k], bit_in};
      assign ge_in    = shift_in >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]   <= ge_in ? 30'(shift_in - {1'b0, den_ff[k]}) : shift_in[29:0];
            quo_ff[k+1]   <= {quo_ff[k][RatioWidth-2:0], ge_in};
            den_ff[k+1]   <= den_ff[k];
            tail_ff[k+1]  <= tail_ff[k];
            sat_ff[k+1]   <= sat_ff[k];
            flags_ff[k+1] <= flags_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[DivSteps];
   assign out_ratio = sat_ff[DivSteps] ? '1 : quo_ff[DivSteps];
   assign out_flags = flags_ff[DivSteps];

endmodule
`default_nettype wire

/* src/csal_sqrt.sv */
// Pipelined digit-by-digit integer square root of R * 2^20, one result
// bit per stage, carrying R and the flags along. Depends on csal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csal_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [csal_pkg::RatioWidth-1:0] in_ratio,
   input  wire csal_pkg::flags_type             in_flags,
   output logic                                 out_valid,
   output logic [csal_pkg::RatioWidth-1:0]      out_ratio,
   output logic [csal_pkg::RootWidth-1:0]       out_root,
   output csal_pkg::flags_type                  out_flags
);
   import csal_pkg::*;

   localparam int VWidth = 2 * RootSteps;

   logic                  stg_vld   [RootSteps+1];
   logic [RatioWidth-1:0] stg_ratio [RootSteps+1];
   logic [RootWidth+3:0]  stg_rem   [RootSteps+1];
   logic [RootWidth-1:0]  stg_root  [RootSteps+1];
   flags_type             stg_flags [RootSteps+1];

   assign stg_vld[0]   = in_valid;
   assign stg_ratio[0] = in_ratio;
   assign stg_rem[0]   = '0;
   assign stg_root[0]  = '0;
   assign stg_flags[0] = in_flags;

   for (genvar k = 0; k < RootSteps; k++) begin : g_step
      logic                  vld_ff;
      logic [RatioWidth-1:0] ratio_ff;
      logic [RootWidth+3:0]  rem_ff;
      logic [RootWidth-1:0]  root_ff;
      flags_type             flags_ff;
      logic [VWidth-1:0]     v_in;
      logic [RootWidth+3:0]  shift_in;
      logic [RootWidth+3:0]  trial_in;
      logic                  ge_in;

      assign v_in     = VWidth'({stg_ratio[k], {FracBits{1'b0}}});
      assign shift_in = {stg_rem[k][RootWidth+1:0], v_in[2*(RootSteps-1-k)+1 -: 2]};
      assign trial_in = {2'b00, stg_root[k], 2'b01};
      assign ge_in    = shift_in >= trial_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= stg_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ratio_ff <= stg_ratio[k];
            rem_ff   <= ge_in ? shift_in - trial_in : shift_in;
            root_ff  <= {stg_root[k][RootWidth-2:0], ge_in};
            flags_ff <= stg_flags[k];
         end
      end

      assign stg_vld[k+1]   = vld_ff;
      assign stg_ratio[k+1] = ratio_ff;
      assign stg_rem[k+1]   = rem_ff;
      assign stg_root[k+1]  = root_ff;
      assign stg_flags[k+1] = flags_ff;
   end

   assign out_valid = stg_vld[RootSteps];
   assign out_ratio = stg_ratio[RootSteps];
   assign out_root  = stg_root[RootSteps];
   assign out_flags = stg_flags[RootSteps];

endmodule
`default_nettype wire

/* src/csal_series.sv */
// Series evaluation: powers of R, coefficient products, signed sum,
// scaling to milli-PSU and clamping, one multiplier level per stage.
// Depends on csal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csal_series (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [csal_pkg::RatioWidth-1:0] in_ratio,
   input  wire logic [csal_pkg::RootWidth-1:0]  in_root,
   input  wire csal_pkg::flags_type             in_flags,
   output logic                                 out_valid,
   output logic [csal_pkg::SalWidth-1:0]        out_salinity,
   output logic                                 out_no_temperature
);
   import csal_pkg::*;

   logic [6:0]      vld_ff;
   flags_type       flags_ff [7];

   logic [24:0]     m1_r_ff;
   logic [22:0]     m1_s_ff;
   logic [29:0]     m1_r2_ff;
   logic [49:0]     r2_full_in;

   logic [22:0]     m2_s_ff;
   logic [34:0]     m2_r3_ff;
   logic [27:0]     m2_p15_ff;
   logic [32:0]     m2_p25_ff;
   logic [34:0]     m2_t2_ff;
   logic [54:0]     r3_full_in;
   logic [47:0]     p15_full_in;
   logic [52:0]     p25_full_in;
   logic [54:0]     t2_full_in;

   logic [37:0]     m3_p35_ff;
   logic [16:0]     m3_t05_ff;
   logic [25:0]     m3_t15_ff;
   logic [34:0]     m3_t2_ff;
   logic [36:0]     m3_t25_ff;
   logic [37:0]     m3_t3_ff;
   logic [57:0]     p35_full_in;
   logic [36:0]     t05_full_in;
   logic [45:0]     t15_full_in;
   logic [56:0]     t25_full_in;
   logic [57:0]     t3_full_in;

   logic [39:0]        m4_t35_ff;
   logic signed [43:0] m4_psum_ff;
   logic [59:0]        t35_full_in;

   logic signed [43:0] m5_sum_ff;

   logic               m6_pos_ff;
   logic               m6_big_ff;
   logic [45:0]        m6_scaled_ff;

   logic [SalWidth-1:0] m7_sal_ff;
   logic                m7_no_temp_ff;

   logic [25:0]         rounded_in;
   logic [SalWidth-1:0] sal_in;

   assign r2_full_in  = 50'(in_ratio) * 50'(in_ratio);
   assign r3_full_in  = 55'(m1_r2_ff) * 55'(m1_r_ff);
   assign p15_full_in = 48'(m1_r_ff) * 48'(m1_s_ff);
   assign p25_full_in = 53'(m1_r2_ff) * 53'(m1_s_ff);
   assign t2_full_in  = 55'(CoefTwo) * 55'(m1_r2_ff);
   assign p35_full_in = 58'(m2_r3_ff) * 58'(m2_s_ff);
   assign t05_full_in = 37'(CoefHalf) * 37'(m2_s_ff);
   assign t15_full_in = 46'(CoefOneHalf) * 46'(m2_p15_ff);
   assign t25_full_in = 57'(CoefTwoHalf) * 57'(m2_p25_ff);
   assign t3_full_in  = 58'(CoefThree) * 58'(m2_r3_ff);
   assign t35_full_in = 60'(CoefThreeHalf) * 60'(m3_p35_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff[0] <= in_flags;
         for (int i = 1; i < 7; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
         m1_r_ff   <= in_ratio;
         m1_s_ff   <= in_root;
         m1_r2_ff  <= r2_full_in[49:20];
         m2_s_ff   <= m1_s_ff;
         m2_r3_ff  <= r3_full_in[54:20];
         m2_p15_ff <= p15_full_in[47:20];
         m2_p25_ff <= p25_full_in[52:20];
         m2_t2_ff  <= t2_full_in[54:20];
         m3_p35_ff <= p35_full_in[57:20];
         m3_t05_ff <= t05_full_in[36:20];
         m3_t15_ff <= t15_full_in[45:20];
         m3_t2_ff  <= m2_t2_ff;
         m3_t25_ff <= t25_full_in[56:20];
         m3_t3_ff  <= t3_full_in[57:20];
         m4_t35_ff <= t35_full_in[59:20];
         m4_psum_ff <= $signed(44'(m3_t05_ff)) - $signed(44'(m3_t15_ff))
                     + $signed(44'(m3_t2_ff)) + $signed(44'(m3_t25_ff))
                     - $signed(44'(m3_t3_ff));
         m5_sum_ff <= m4_psum_ff + $signed(44'(m4_t35_ff));
         m6_pos_ff <= ~m5_sum_ff[43] & (m5_sum_ff != 44'sd0);
         m6_big_ff <= m5_sum_ff[42:36] != 7'd0;
         m6_scaled_ff <= 46'(m5_sum_ff[35:0]) * 46'd1000 + 46'(1 << (FracBits - 1));
         m7_sal_ff <= sal_in;
         m7_no_temp_ff <= flags_ff[5].no_temp;
      end
   end

   always_comb begin
      rounded_in = m6_scaled_ff[45:20];
      if (flags_ff[5].no_temp || flags_ff[5].zero || !m6_pos_ff) begin
         sal_in = '0;
      end else if (m6_big_ff || rounded_in > 26'(SalMax)) begin
         sal_in = SalMax;
      end else begin
         sal_in = rounded_in[SalWidth-1:0];
      end
   end

   assign out_valid          = vld_ff[6];
   assign out_salinity       = m7_sal_ff;
   assign out_no_temperature = m7_no_temp_ff;

endmodule
`default_nettype wire

/* src/conductivity_to_salinity.sv */
// Top level of the conductivity to salinity converter: CSR registers,
// pipeline flow control and the ratio, root and series units.
// Depends on csal_pkg, csal_div, csal_sqrt and csal_series.
`timescale 1ns / 1ps
`default_nettype none
// A reading is accepted in every cycle in which the result side is not
// stalled. Its salinity is formed in order: registers form the temperature
// factor and denominator, a register then checks for ratio saturation, 25
// divider stages give R one bit per stage, 23 root stages give sqrt(R) one
// bit per stage, and 7 stages evaluate the series and clamp. The whole
// pipeline holds while a result beat waits; the CSR port is always ready and
// should be written only while no reading is in flight.
module conductivity_to_salinity (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [csal_pkg::EcWidth-1:0]   req_conductivity,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [csal_pkg::SalWidth-1:0]       rsp_salinity,
   output logic                                rsp_no_temperature,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [0:0]                     csr_index,
   input  wire logic [csal_pkg::TempWidth-1:0] csr_data
);
   import csal_pkg::*;

   logic [TempWidth-1:0]  comp_temp_ff;
   logic                  temp_known_ff;
   logic                  en;
   logic                  div_valid;
   logic [RatioWidth-1:0] div_ratio;
   flags_type             div_flags;
   logic                  sq_valid;
   logic [RatioWidth-1:0] sq_ratio;
   logic [RootWidth-1:0]  sq_root;
   flags_type             sq_flags;

   assign csr_ready = 1'b1;
   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_temp_ff  <= TempReset;
         temp_known_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COMP_TEMP:  comp_temp_ff  <= csr_data;
            CSR_TEMP_KNOWN: temp_known_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   csal_div u_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .in_ec         (req_conductivity),
      .in_temp       (comp_temp_ff),
      .in_temp_known (temp_known_ff),
      .out_valid     (div_valid),
      .out_ratio     (div_ratio),
      .out_flags     (div_flags)
   );

   csal_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_ratio  (div_ratio),
      .in_flags  (div_flags),
      .out_valid (sq_valid),
      .out_ratio (sq_ratio),
      .out_root  (sq_root),
      .out_flags (sq_flags)
   );

   csal_series u_series (
      .clock              (clock),
      .reset              (reset),
      .en                 (en),
      .in_valid           (sq_valid),
      .in_ratio           (sq_ratio),
      .in_root            (sq_root),
      .in_flags           (sq_flags),
      .out_valid          (rsp_valid),
      .out_salinity       (rsp_salinity),
      .out_no_temperature (rsp_no_temperature)
   );

endmodule
`default_nettype wire

/* src/csal_checker.sv */
// Port-level checks for the converter, bound to the top level.
// Depends on assert_macros.svh and csal_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module csal_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [csal_pkg::SalWidth-1:0]  rsp_salinity,
   input wire logic                           rsp_no_temperature
);
   import csal_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_salinity) && $stable(rsp_no_temperature), "result beat changed while stalled")
   `ASSERT_SAME(a_sal_range, clock, reset, rsp_valid, rsp_salinity <= SalMax, "salinity above clamp")
   `ASSERT_SAME(a_no_temp_zero, clock, reset, rsp_valid && rsp_no_temperature, rsp_salinity == '0, "salinity not zero without temperature")
   `ASSERT_SAME(a_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready, "input stalled while output free")

endmodule

bind conductivity_to_salinity csal_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_salinity       (rsp_salinity),
   .rsp_no_temperature (rsp_no_temperature)
);
`default_nettype wire
